>>> rtl/core/bbpm_pkg.sv
// ----------------------------------------------------------------------------
// bbpm_pkg
// Shared types and codes for the block buffer pool manager.
// ----------------------------------------------------------------------------
package bbpm_pkg;

  localparam int REQ_W   = 3;
  localparam int KIND_W  = 3;
  localparam int FILE_W  = 8;
  localparam int BLOCK_W = 24;
  localparam int FBLK_W  = 25;
  localparam int SLOT_W  = 4;
  localparam int REFS_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET     = 3'd0,
    REQ_RELEASE = 3'd1,
    REQ_PIN     = 3'd2,
    REQ_MARK    = 3'd3,
    REQ_FLUSH   = 3'd4,
    REQ_CLEAR   = 3'd5,
    REQ_SYNC    = 3'd6
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    K_HIT  = 3'd0,
    K_READ = 3'd1,
    K_NEW  = 3'd2,
    K_FULL = 3'd3,
    K_WB   = 3'd4,
    K_DONE = 3'd5
  } kind_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_VICTIM = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_SEL    = 7'b0010000,
    S_SELOP  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic [REFS_W-1:0]  refs;
  } entry_t;

  typedef struct packed {
    logic tag_hit;
    logic file_hit;
    logic free_clean;
    logic free_dirty;
    logic wb_need;
    logic ref_zero;
    logic ref_max;
  } eval_t;

endpackage

>>> rtl/core/bbpm_tag_ram.sv
// ----------------------------------------------------------------------------
// bbpm_tag_ram
// Slot tag and reference count memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbpm_tag_ram import bbpm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bbpm_slot_eval.sv
// ----------------------------------------------------------------------------
// bbpm_slot_eval
// Shared compare unit: classifies one slot against the current request.
// ----------------------------------------------------------------------------
module bbpm_slot_eval import bbpm_pkg::*; (
  input  entry_t             ent_i,
  input  logic               valid_i,
  input  logic               dirty_i,
  input  logic [FILE_W-1:0]  file_i,
  input  logic [BLOCK_W-1:0] block_i,
  output eval_t              eval_o
);

  logic file_eq;
  logic zero;

  assign file_eq = (ent_i.file == file_i);
  assign zero    = (ent_i.refs == '0);

  always_comb begin
    eval_o.tag_hit    = valid_i && file_eq && (ent_i.block == block_i);
    eval_o.file_hit   = valid_i && file_eq;
    eval_o.free_clean = valid_i && zero && !dirty_i;
    eval_o.free_dirty = valid_i && zero && dirty_i;
    eval_o.wb_need    = valid_i && dirty_i;
    eval_o.ref_zero   = zero;
    eval_o.ref_max    = (ent_i.refs == '1);
  end

endmodule

>>> rtl/core/block_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// block_buffer_pool_manager
// Tag, reference count and replacement control for a pool of block buffers.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start_i high and busy_o low; busy_o
// then stays high until the final result. Results leave one per cycle, each
// marked by res_strobe_o for a single cycle, and must be taken as they come.
// The tag memory has one read port, which a scan walks one slot per cycle: a
// get stops at the first slot that hits, and a get that misses reads every slot,
// then picks a victim and fills it (no fill when the pool is full); clear file
// and sync read every slot, and release, pin and flush read the selected slot
// (none for a slot beyond the pool); mark dirty and unused codes read no slot.
// ----------------------------------------------------------------------------
module block_buffer_pool_manager import bbpm_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [FILE_W-1:0]  file_id_i,
  input  logic [BLOCK_W-1:0] block_num_i,
  input  logic [FBLK_W-1:0]  file_blocks_i,
  input  logic [SLOT_W-1:0]  slot_sel_i,
  output logic               res_strobe_o,
  output logic [KIND_W-1:0]  kind_o,
  output logic [SLOT_W-1:0]  slot_out_o,
  output logic [FILE_W-1:0]  file_out_o,
  output logic [BLOCK_W-1:0] block_out_o,
  output logic               last_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  state_e             state_q, state_d;
  req_e               op_q, op_d;
  logic [FILE_W-1:0]  file_q, file_d;
  logic [BLOCK_W-1:0] block_q, block_d;
  logic               new_q, new_d;
  logic [SW-1:0]      sel_q, sel_d;
  logic [SW-1:0]      cnt_q, cnt_d;
  logic               iss_q, iss_d;
  logic               rd_v_q, rd_v_d;
  logic [SW-1:0]      rd_idx_q, rd_idx_d;
  logic               empty_f_q, empty_f_d;
  logic [SW-1:0]      empty_idx_q, empty_idx_d;
  logic               clean_f_q, clean_f_d;
  logic [SW-1:0]      clean_idx_q, clean_idx_d;
  logic               dty_f_q, dty_f_d;
  logic [SW-1:0]      dty_idx_q, dty_idx_d;
  logic [FILE_W-1:0]  dty_file_q, dty_file_d;
  logic [BLOCK_W-1:0] dty_block_q, dty_block_d;
  logic [SW-1:0]      vic_q, vic_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [SLOTS-1:0]   dirty_q, dirty_d;
  logic [SLOTS-1:0]   refs_ok_q, refs_ok_d;

  logic               strobe_q, strobe_d;
  kind_e              kind_q, kind_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [FILE_W-1:0]  fout_q, fout_d;
  logic [BLOCK_W-1:0] bout_q, bout_d;
  logic               last_q, last_d;

  logic               we;
  logic [SW-1:0]      waddr;
  entry_t             wdata;
  logic               re;
  logic [SW-1:0]      raddr;
  entry_t             rdata;
  entry_t             rent;

  logic [SW-1:0]      ev_idx;
  eval_t              ev;
  logic               sel_ok;
  logic [SW-1:0]      sel_idx;
  logic [SW-1:0]      vic;

  bbpm_tag_ram #(
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ev_idx = (state_q == S_SELOP) ? sel_q : rd_idx_q;

  // count of a never written slot reads as zero
  always_comb begin
    rent = rdata;
    if (!refs_ok_q[ev_idx]) begin
      rent.refs = '0;
    end
  end

  bbpm_slot_eval u_slot_eval (
    .ent_i   (rent),
    .valid_i (valid_q[ev_idx]),
    .dirty_i (dirty_q[ev_idx]),
    .file_i  (file_q),
    .block_i (block_q),
    .eval_o  (ev)
  );

  assign sel_ok  = (32'(slot_sel_i) < SLOTS);
  assign sel_idx = SW'(slot_sel_i);
  assign vic     = empty_f_q ? empty_idx_q : (clean_f_q ? clean_idx_q : dty_idx_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    file_d      = file_q;
    block_d     = block_q;
    new_d       = new_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    empty_f_d   = empty_f_q;
    empty_idx_d = empty_idx_q;
    clean_f_d   = clean_f_q;
    clean_idx_d = clean_idx_q;
    dty_f_d     = dty_f_q;
    dty_idx_d   = dty_idx_q;
    dty_file_d  = dty_file_q;
    dty_block_d = dty_block_q;
    vic_d       = vic_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    refs_ok_d   = refs_ok_q;
    strobe_d    = 1'b0;
    kind_d      = kind_q;
    slot_d      = slot_q;
    fout_d      = fout_q;
    bout_d      = bout_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = rd_idx_q;
    wdata       = rent;
    re          = 1'b0;
    raddr       = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d      = req_e'(req_type_i);
          file_d    = file_id_i;
          block_d   = block_num_i;
          new_d     = ({1'b0, block_num_i} >= file_blocks_i);
          sel_d     = sel_idx;
          cnt_d     = '0;
          empty_f_d = 1'b0;
          clean_f_d = 1'b0;
          dty_f_d   = 1'b0;
          unique case (req_e'(req_type_i)) inside
            REQ_GET, REQ_CLEAR, REQ_SYNC: begin
              state_d = S_SCAN;
              iss_d   = 1'b1;
            end
            REQ_RELEASE, REQ_PIN, REQ_FLUSH: begin
              state_d = sel_ok ? S_SEL : S_DONE;
            end
            REQ_MARK: begin
              if (sel_ok && valid_q[sel_idx]) begin
                dirty_d[sel_idx] = 1'b1;
              end
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one slot per cycle, classify the slot read in the cycle before
        if (iss_q) begin
          re       = 1'b1;
          raddr    = cnt_q;
          rd_v_d   = 1'b1;
          rd_idx_d = cnt_q;
          if (cnt_q == LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (rd_v_q) begin
          case (op_q)
            REQ_GET: begin
              if (ev.tag_hit) begin
                we         = 1'b1;
                waddr      = rd_idx_q;
                wdata.refs = ev.ref_max ? rent.refs : rent.refs + 1'b1;
                strobe_d   = 1'b1;
                kind_d     = K_HIT;
                slot_d     = SLOT_W'(rd_idx_q);
                fout_d     = file_q;
                bout_d     = block_q;
                last_d     = 1'b1;
                iss_d      = 1'b0;
                rd_v_d     = 1'b0;
                state_d    = S_IDLE;
              end else begin
                if (!valid_q[rd_idx_q] && !empty_f_q) begin
                  empty_f_d   = 1'b1;
                  empty_idx_d = rd_idx_q;
                end
                if (ev.free_clean && !clean_f_q) begin
                  clean_f_d   = 1'b1;
                  clean_idx_d = rd_idx_q;
                end
                if (ev.free_dirty && !dty_f_q) begin
                  dty_f_d     = 1'b1;
                  dty_idx_d   = rd_idx_q;
                  dty_file_d  = rdata.file;
                  dty_block_d = rdata.block;
                end
                if (rd_idx_q == LAST_IDX) begin
                  state_d = S_VICTIM;
                end
              end
            end
            REQ_CLEAR: begin
              if (ev.file_hit) begin
                if (ev.wb_need) begin
                  strobe_d = 1'b1;
                  kind_d   = K_WB;
                  slot_d   = SLOT_W'(rd_idx_q);
                  fout_d   = rdata.file;
                  bout_d   = rdata.block;
                  last_d   = 1'b0;
                end
                we                = 1'b1;
                waddr             = rd_idx_q;
                wdata.refs        = '0;
                valid_d[rd_idx_q] = 1'b0;
                dirty_d[rd_idx_q] = 1'b0;
              end
              if (rd_idx_q == LAST_IDX) begin
                state_d = S_DONE;
              end
            end
            default: begin
              if (ev.wb_need) begin
                strobe_d          = 1'b1;
                kind_d            = K_WB;
                slot_d            = SLOT_W'(rd_idx_q);
                fout_d            = rdata.file;
                bout_d            = rdata.block;
                last_d            = 1'b0;
                dirty_d[rd_idx_q] = 1'b0;
              end
              if (rd_idx_q == LAST_IDX) begin
                state_d = S_DONE;
              end
            end
          endcase
        end
      end

      S_VICTIM: begin
        if (!empty_f_q && !clean_f_q && !dty_f_q) begin
          strobe_d = 1'b1;
          kind_d   = K_FULL;
          slot_d   = '0;
          fout_d   = file_q;
          bout_d   = block_q;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          if (!empty_f_q && !clean_f_q) begin
            strobe_d = 1'b1;
            kind_d   = K_WB;
            slot_d   = SLOT_W'(dty_idx_q);
            fout_d   = dty_file_q;
            bout_d   = dty_block_q;
            last_d   = 1'b0;
          end
          we           = 1'b1;
          waddr        = vic;
          wdata.file   = file_q;
          wdata.block  = block_q;
          wdata.refs   = REFS_W'(1);
          valid_d[vic] = 1'b1;
          dirty_d[vic] = new_q;
          vic_d        = vic;
          state_d      = S_FILL;
        end
      end

      S_FILL: begin
        strobe_d = 1'b1;
        kind_d   = new_q ? K_NEW : K_READ;
        slot_d   = SLOT_W'(vic_q);
        fout_d   = file_q;
        bout_d   = block_q;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_SEL: begin
        re      = 1'b1;
        raddr   = sel_q;
        state_d = S_SELOP;
      end

      S_SELOP: begin
        waddr = sel_q;
        case (op_q)
          REQ_RELEASE: begin
            if (!ev.ref_zero) begin
              we         = 1'b1;
              wdata.refs = rent.refs - 1'b1;
            end
          end
          REQ_PIN: begin
            if (!ev.ref_max) begin
              we         = 1'b1;
              wdata.refs = rent.refs + 1'b1;
            end
          end
          REQ_FLUSH: begin
            if (ev.wb_need) begin
              strobe_d       = 1'b1;
              kind_d         = K_WB;
              slot_d         = SLOT_W'(sel_q);
              fout_d         = rdata.file;
              bout_d         = rdata.block;
              last_d         = 1'b0;
              dirty_d[sel_q] = 1'b0;
            end
          end
          default: begin
          end
        endcase
        state_d = S_DONE;
      end

      S_DONE: begin
        strobe_d = 1'b1;
        kind_d   = K_DONE;
        slot_d   = '0;
        fout_d   = '0;
        bout_d   = '0;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (we) begin
      refs_ok_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= 1'b0;
      rd_v_q    <= 1'b0;
      valid_q   <= '0;
      dirty_q   <= '0;
      refs_ok_q <= '0;
      strobe_q  <= 1'b0;
      empty_f_q <= 1'b0;
      clean_f_q <= 1'b0;
      dty_f_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      rd_v_q    <= rd_v_d;
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      refs_ok_q <= refs_ok_d;
      strobe_q  <= strobe_d;
      empty_f_q <= empty_f_d;
      clean_f_q <= clean_f_d;
      dty_f_q   <= dty_f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    file_q      <= file_d;
    block_q     <= block_d;
    new_q       <= new_d;
    sel_q       <= sel_d;
    cnt_q       <= cnt_d;
    rd_idx_q    <= rd_idx_d;
    empty_idx_q <= empty_idx_d;
    clean_idx_q <= clean_idx_d;
    dty_idx_q   <= dty_idx_d;
    dty_file_q  <= dty_file_d;
    dty_block_q <= dty_block_d;
    vic_q       <= vic_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    fout_q      <= fout_d;
    bout_q      <= bout_d;
    last_q      <= last_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign kind_o       = kind_q;
  assign slot_out_o   = slot_q;
  assign file_out_o   = fout_q;
  assign block_out_o  = bout_q;
  assign last_o       = last_q;

  a_final_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy_o)
    else $error("final result while request still running");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !res_strobe_o)
    else $error("result right after transfer of a new request");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (last_o == (kind_o != K_WB)))
    else $error("last flag does not match result kind");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rd_v_q && !iss_q))
    else $error("scan pipeline active while idle");

  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ~valid_q) == '0)
    else $error("dirty bit set on empty slot");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block buffer pool manager. A queue of requests
// (directed cases, a reference count run, a pool fill and eviction
// scenario, then random request mixes) feeds a clocked driver. A clocked
// monitor tracks the slot tags, dirty bits and reference counts, derives the
// results each accepted request must produce and checks every result field.
// ----------------------------------------------------------------------------
module tb_top import bbpm_pkg::*;;

  localparam int SLOTS          = 16;
  localparam int RAND_ITEMS     = 160;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam logic [FBLK_W-1:0] FBLK_MAX  = 25'd16777216;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic [FBLK_W-1:0]  fblocks;
    logic [SLOT_W-1:0]  sel;
    int                 idle_pct;
    bit                 drain;
  } request_t;

  typedef struct {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic               last;
  } pool_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [REQ_W-1:0]   req_type_i = '0;
  logic [FILE_W-1:0]  file_id_i = '0;
  logic [BLOCK_W-1:0] block_num_i = '0;
  logic [FBLK_W-1:0]  file_blocks_i = '0;
  logic [SLOT_W-1:0]  slot_sel_i = '0;
  logic               res_strobe_o;
  logic [KIND_W-1:0]  kind_o;
  logic [SLOT_W-1:0]  slot_out_o;
  logic [FILE_W-1:0]  file_out_o;
  logic [BLOCK_W-1:0] block_out_o;
  logic               last_o;

  request_t     req_backlog[$];
  pool_result_t pending_results[$];
  int           errors = 0;
  int           stall_cycles = 0;
  int           cur_idle_pct = 0;
  bit           took_item = 1'b0;

  // tracked pool state
  bit                 pool_valid[SLOTS];
  bit                 pool_dirty[SLOTS];
  logic [FILE_W-1:0]  pool_file[SLOTS];
  logic [BLOCK_W-1:0] pool_block[SLOTS];
  logic [REFS_W-1:0]  pool_refs[SLOTS];

  block_buffer_pool_manager #(.SLOTS(SLOTS)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .req_type_i, .file_id_i, .block_num_i, .file_blocks_i, .slot_sel_i,
    .res_strobe_o, .kind_o, .slot_out_o, .file_out_o, .block_out_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  task automatic expect_result(kind_e k, int slot, logic [FILE_W-1:0] file,
                               logic [BLOCK_W-1:0] block, logic last);
    pool_result_t r;
    r.kind  = k;
    r.slot  = slot[SLOT_W-1:0];
    r.file  = file;
    r.block = block;
    r.last  = last;
    pending_results.push_back(r);
  endtask

  task automatic write_back_slot(int s);
    if (pool_valid[s] && pool_dirty[s]) begin
      expect_result(K_WB, s, pool_file[s], pool_block[s], 1'b0);
      pool_dirty[s] = 1'b0;
    end
  endtask

  task automatic predict_pool_response(logic [REQ_W-1:0] req, logic [FILE_W-1:0] file,
                                       logic [BLOCK_W-1:0] block,
                                       logic [FBLK_W-1:0] fblocks,
                                       logic [SLOT_W-1:0] sel);
    int s;
    int victim;
    bit hit;
    victim = -1;
    hit = 1'b0;
    case (req)
      REQ_GET: begin
        for (s = 0; s < SLOTS; s++) begin
          if (!hit && pool_valid[s] && pool_file[s] == file && pool_block[s] == block) begin
            hit = 1'b1;
            if (pool_refs[s] != '1) pool_refs[s]++;
            expect_result(K_HIT, s, file, block, 1'b1);
          end
        end
        if (!hit) begin
          for (s = 0; s < SLOTS && victim < 0; s++)
            if (!pool_valid[s]) victim = s;
          for (s = 0; s < SLOTS && victim < 0; s++)
            if (pool_refs[s] == '0 && !pool_dirty[s]) victim = s;
          for (s = 0; s < SLOTS && victim < 0; s++)
            if (pool_refs[s] == '0 && pool_dirty[s]) victim = s;
          if (victim < 0) begin
            expect_result(K_FULL, 0, file, block, 1'b1);
          end else begin
            write_back_slot(victim);
            pool_valid[victim] = 1'b1;
            pool_file[victim]  = file;
            pool_block[victim] = block;
            pool_refs[victim]  = 8'd1;
            if ({1'b0, block} < fblocks) begin
              pool_dirty[victim] = 1'b0;
              expect_result(K_READ, victim, file, block, 1'b1);
            end else begin
              pool_dirty[victim] = 1'b1;
              expect_result(K_NEW, victim, file, block, 1'b1);
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (sel < SLOTS && pool_refs[sel] != '0) pool_refs[sel]--;
      end
      REQ_PIN: begin
        if (sel < SLOTS && pool_refs[sel] != '1) pool_refs[sel]++;
      end
      REQ_MARK: begin
        if (sel < SLOTS && pool_valid[sel]) pool_dirty[sel] = 1'b1;
      end
      REQ_FLUSH: begin
        if (sel < SLOTS) write_back_slot(sel);
      end
      REQ_CLEAR: begin
        for (s = 0; s < SLOTS; s++) begin
          if (pool_valid[s] && pool_file[s] == file) begin
            write_back_slot(s);
            pool_valid[s] = 1'b0;
            pool_dirty[s] = 1'b0;
            pool_refs[s]  = '0;
          end
        end
      end
      REQ_SYNC: begin
        for (s = 0; s < SLOTS; s++) write_back_slot(s);
      end
      default: begin
      end
    endcase
    if (req != REQ_GET) expect_result(K_DONE, 0, '0, '0, 1'b1);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic post_request(logic [REQ_W-1:0] req, logic [FILE_W-1:0] file,
                              logic [BLOCK_W-1:0] block, logic [FBLK_W-1:0] fblocks,
                              logic [SLOT_W-1:0] sel, bit drain = 1'b0);
    request_t r;
    r.req      = req;
    r.file     = file;
    r.block    = block;
    r.fblocks  = fblocks;
    r.sel      = sel;
    r.idle_pct = cur_idle_pct;
    r.drain    = drain;
    req_backlog.push_back(r);
  endtask

  // driver
  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni && (took_item || !start_i)) begin
      if (req_backlog.size() != 0 &&
          !(req_backlog[0].drain && (pending_results.size() != 0 || busy_o)) &&
          $urandom_range(99) >= req_backlog[0].idle_pct) begin
        nxt = req_backlog.pop_front();
        req_type_i    <= nxt.req;
        file_id_i     <= nxt.file;
        block_num_i   <= nxt.block;
        file_blocks_i <= nxt.fblocks;
        slot_sel_i    <= nxt.sel;
        start_i       <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pool_result_t want;
    took_item <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (start_i && !busy_o)
        predict_pool_response(req_type_i, file_id_i, block_num_i, file_blocks_i, slot_sel_i);
      if (res_strobe_o) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d slot %0d", kind_o, slot_out_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("slot_out", 32'(want.slot), 32'(slot_out_o));
          check_field("file_out", 32'(want.file), 32'(file_out_o));
          check_field("block_out", 32'(want.block), 32'(block_out_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_strobe_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL block_buffer_pool_manager");
      $finish;
    end
  end

  initial begin
    int idle_by_phase[4];
    int base, n, i, b, phase;
    logic [FILE_W-1:0]  f;
    logic [BLOCK_W-1:0] blk;
    logic [FBLK_W-1:0]  fb;
    idle_by_phase = '{0, 66, 0, 31};
    for (i = 0; i < SLOTS; i++) begin
      pool_valid[i] = 1'b0;
      pool_dirty[i] = 1'b0;
      pool_file[i]  = '0;
      pool_block[i] = '0;
      pool_refs[i]  = '0;
    end

    // directed: field extremes, every request type, empty slot handling
    post_request(REQ_GET, 8'h00, 24'h000000, 25'd0, 4'd0);
    post_request(REQ_GET, 8'h00, 24'h000000, 25'd0, 4'd0);
    post_request(REQ_GET, 8'hff, 24'hffffff, FBLK_MAX, 4'd15);
    post_request(REQ_GET, 8'hff, 24'hffffff, 25'd0, 4'd0);
    post_request(REQ_GET, 8'h80, 24'd5, 25'd5, 4'd0);
    post_request(REQ_GET, 8'h80, 24'd6, 25'd7, 4'd0);
    repeat (3) post_request(REQ_RELEASE, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_PIN, 8'h00, 24'd0, 25'd0, 4'd9);
    post_request(REQ_RELEASE, 8'h00, 24'd0, 25'd0, 4'd9);
    post_request(REQ_MARK, 8'h00, 24'd0, 25'd0, 4'd9);
    post_request(REQ_FLUSH, 8'h00, 24'd0, 25'd0, 4'd9);
    post_request(REQ_MARK, 8'h00, 24'd0, 25'd0, 4'd1);
    post_request(REQ_FLUSH, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_FLUSH, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_SYNC, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_MARK, 8'h00, 24'd0, 25'd0, 4'd3);
    post_request(REQ_CLEAR, 8'h80, 24'd0, 25'd0, 4'd0);
    post_request(REQ_UNUSED, 8'hff, 24'hffffff, FBLK_MAX, 4'd15);
    post_request(REQ_CLEAR, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_CLEAR, 8'hff, 24'd0, 25'd0, 4'd0, 1'b1);

    // reference count run on one slot, release saturating at zero
    post_request(REQ_GET, 8'ha5, 24'h123456, 25'd0, 4'd0);
    repeat (4) post_request(REQ_PIN, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_GET, 8'ha5, 24'h123456, 25'd0, 4'd0);
    repeat (8) post_request(REQ_RELEASE, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_CLEAR, 8'ha5, 24'd0, 25'd0, 4'd0);

    // fill the pool, hit pool full, then evict clean before dirty
    for (b = 0; b < SLOTS; b++)
      post_request(REQ_GET, 8'h01, BLOCK_W'(b), FBLK_W'(b[0] ? b : b + 1), 4'd0);
    post_request(REQ_GET, 8'h01, BLOCK_W'(SLOTS), 25'd0, 4'd0);
    post_request(REQ_RELEASE, 8'h00, 24'd0, 25'd0, 4'd1);
    post_request(REQ_RELEASE, 8'h00, 24'd0, 25'd0, 4'd4);
    post_request(REQ_GET, 8'h02, 24'd0, 25'd1, 4'd0);
    post_request(REQ_GET, 8'h02, 24'd1, 25'd2, 4'd0);
    post_request(REQ_SYNC, 8'h00, 24'd0, 25'd0, 4'd0);
    post_request(REQ_CLEAR, 8'h01, 24'd0, 25'd0, 4'd0);
    post_request(REQ_CLEAR, 8'h02, 24'd0, 25'd0, 4'd0);

    // random request mixes over the idling phases
    base = req_backlog.size();
    while (req_backlog.size() - base < RAND_ITEMS) begin
      phase = (req_backlog.size() - base) * 4 / RAND_ITEMS;
      cur_idle_pct = idle_by_phase[phase > 3 ? 3 : phase];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(3, 12);
          for (i = 0; i < n; i++) begin
            f = FILE_W'($urandom_range(0, 3));
            blk = ($urandom_range(0, 9) == 0) ? BLOCK_W'($urandom_range(0, 24'hffffff))
                                              : BLOCK_W'($urandom_range(0, 23));
            case ($urandom_range(0, 3))
              0: fb = {1'b0, blk};
              1: fb = {1'b0, blk} + 25'd1;
              2: fb = FBLK_W'($urandom_range(0, 16777216));
              default: fb = '0;
            endcase
            post_request(REQ_GET, f, blk, fb, SLOT_W'($urandom_range(0, 15)),
                         i == 0 && $urandom_range(0, 9) == 0);
          end
        end
        4, 5: begin
          for (i = 0; i < SLOTS; i++)
            if ($urandom_range(99) < 60)
              post_request(REQ_RELEASE, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                           SLOT_W'(i));
        end
        6: begin
          n = $urandom_range(1, 5);
          for (i = 0; i < n; i++)
            post_request(REQ_MARK, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                         SLOT_W'($urandom_range(0, 15)));
          if ($urandom_range(0, 1))
            post_request(REQ_FLUSH, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                         SLOT_W'($urandom_range(0, 15)));
        end
        7: begin
          case ($urandom_range(0, 2))
            0: post_request(REQ_FLUSH, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                            SLOT_W'($urandom_range(0, 15)));
            1: post_request(REQ_CLEAR, FILE_W'($urandom_range(0, 3)), BLOCK_W'($urandom),
                            '0, SLOT_W'($urandom));
            default: post_request(REQ_SYNC, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                                  SLOT_W'($urandom));
          endcase
        end
        8: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++)
            post_request(REQ_PIN, FILE_W'($urandom), BLOCK_W'($urandom), '0,
                         SLOT_W'($urandom_range(0, 15)));
        end
        default: begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++)
            post_request(REQ_W'($urandom_range(0, 7)), FILE_W'($urandom),
                         BLOCK_W'($urandom), FBLK_W'($urandom_range(0, 16777216)),
                         SLOT_W'($urandom_range(0, 15)));
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || start_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS block_buffer_pool_manager");
    end else begin
      $display("FAIL block_buffer_pool_manager");
    end
    $finish;
  end

endmodule
